// ===== rtl/epcf_pkg.sv =====
// Shared types, constants and arithmetic helpers for the event pixel complementary filter.
package epcf_pkg;

	localparam int IMG_WIDTH  = 256;
	localparam int IMG_HEIGHT = 256;
	localparam int NPIX       = IMG_WIDTH * IMG_HEIGHT;
	localparam int ADDR_W     = $clog2(NPIX);
	localparam int COORD_W    = 11;

	localparam logic [11:0] FRAME_RESET = 12'd1659;

	localparam logic [1:0] CMD_EVENT  = 2'd0;
	localparam logic [1:0] CMD_FRAME  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] REG_TH_ON   = 2'd0;
	localparam logic [1:0] REG_TH_OFF  = 2'd1;
	localparam logic [1:0] REG_CUTOFF  = 2'd2;
	localparam logic [1:0] REG_GUIDE   = 2'd3;

	typedef enum logic [2:0] {
		KIND_EVENT,
		KIND_FRAME,
		KIND_READ,
		KIND_NOP,
		KIND_OUTSIDE
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_EXP,
		ST_BLD,
		ST_FIN,
		ST_SQ,
		ST_FLOG
	} back_state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] time_us;
		logic [7:0]  col;
		logic [7:0]  row;
		logic        polarity;
		logic [7:0]  frame_pixel;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] log_intensity;
		logic signed [15:0] guide_value;
		logic               status;
	} out_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [31:0]       time_us;
		logic [ADDR_W-1:0] addr;
		logic              polarity;
		logic [7:0]        frame_pixel;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	typedef struct packed {
		logic [11:0]        th_on;
		logic signed [12:0] th_off;
		logic [23:0]        cutoff;
		logic [23:0]        guide_rate;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] log_v;
		logic signed [15:0] guide_v;
		logic [31:0]        last;
		logic [11:0]        frame;
	} pix_t;

	function automatic logic [15:0] exp_tab(input logic [3:0] k);
		logic [15:0] t;
		case (k)
			4'd0:    t = 16'd65520;
			4'd1:    t = 16'd65504;
			4'd2:    t = 16'd65472;
			4'd3:    t = 16'd65408;
			4'd4:    t = 16'd65280;
			4'd5:    t = 16'd65026;
			4'd6:    t = 16'd64520;
			4'd7:    t = 16'd63520;
			4'd8:    t = 16'd61565;
			4'd9:    t = 16'd57835;
			4'd10:   t = 16'd51039;
			4'd11:   t = 16'd39750;
			4'd12:   t = 16'd24109;
			4'd13:   t = 16'd8869;
			4'd14:   t = 16'd1200;
			default: t = 16'd22;
		endcase
		return t;
	endfunction

	function automatic logic signed [19:0] rnd16(input logic signed [34:0] v);
		logic [34:0] mag;
		logic [34:0] r;
		mag = v[34] ? 35'(-v) : 35'(v);
		r   = (mag + 35'd32768) >> 16;
		return v[34] ? -$signed(r[19:0]) : $signed(r[19:0]);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		logic signed [15:0] r;
		if (v > 21'sd32767)
			r = 16'sh7FFF;
		else if (v < -21'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// ===== rtl/event_pixel_complementary_filter.sv =====
// Top level: configuration registers, front end queue and back end datapath.
// Events and readouts pass a 16-step exponent loop, frame writes a 16-step squaring
// loop; other and out-of-order requests skip both loops.
// The back end works one pixel at a time and takes no new request before the last is done.
// Reset: a pass over all 65536 pixel addresses clears the pixel memory; no request is taken meanwhile,
// configuration writes are taken at once.
module event_pixel_complementary_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  epcf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output epcf_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	import epcf_pkg::*;

	cfg_t      cfg_q;
	job_req_t  job_req;
	back_ctl_t back_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.th_on      <= 12'd410;
			cfg_q.th_off     <= -13'sd410;
			cfg_q.cutoff     <= 24'd134918;
			cfg_q.guide_rate <= 24'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TH_ON:  cfg_q.th_on      <= cfg_data[11:0];
				REG_TH_OFF: cfg_q.th_off     <= $signed(cfg_data[12:0]);
				REG_CUTOFF: cfg_q.cutoff     <= cfg_data;
				REG_GUIDE:  cfg_q.guide_rate <= cfg_data;
				default:    cfg_q            <= cfg_q;
			endcase
		end
	end

	epcf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.job_req  (job_req),
		.back_ctl (back_ctl)
	);

	epcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_req   (job_req),
		.back_ctl  (back_ctl),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/epcf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module epcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/epcf_front.sv =====
// Front end: accept and classify requests, queue them for the back end.
module epcf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  epcf_pkg::in_item_t in_data,
	output epcf_pkg::job_req_t job_req,
	input  epcf_pkg::back_ctl_t back_ctl
);
	import epcf_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	logic       outside;
	job_t       job_in;

	always_comb begin
		outside = (COORD_W'(in_data.col) >= COORD_W'(IMG_WIDTH))
			|| (COORD_W'(in_data.row) >= COORD_W'(IMG_HEIGHT));
		job_in.time_us     = in_data.time_us;
		job_in.polarity    = in_data.polarity;
		job_in.frame_pixel = in_data.frame_pixel;
		job_in.addr        = ADDR_W'(int'(in_data.row) * IMG_WIDTH + int'(in_data.col));
		unique case (in_data.cmd)
			CMD_EVENT: job_in.kind = KIND_EVENT;
			CMD_FRAME: job_in.kind = KIND_FRAME;
			CMD_READ:  job_in.kind = KIND_READ;
			default:   job_in.kind = KIND_NOP;
		endcase
		if (outside)
			job_in.kind = KIND_OUTSIDE;
	end

	assign in_stall      = (cnt_q == 2'd2) || back_ctl.clearing;
	assign push          = in_valid && !in_stall;
	assign pop           = back_ctl.pop && (cnt_q != 2'd0);
	assign job_req.valid = (cnt_q != 2'd0);
	assign job_req.job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/epcf_back.sv =====
// Back end: pixel memory read-modify-write, decay, blend and frame log datapath.
module epcf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  epcf_pkg::cfg_t      cfg,
	input  epcf_pkg::job_req_t  job_req,
	output epcf_pkg::back_ctl_t back_ctl,
	output logic                out_valid,
	input  logic                out_stall,
	output epcf_pkg::out_item_t out_data
);
	import epcf_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic [ADDR_W-1:0] clr_q;

	job_t        job_q;
	pix_t        word_q;
	logic [31:0] dt_q;
	logic [15:0] ac_q;
	logic [15:0] ag_q;
	logic        cbig_q;
	logic        gbig_q;
	logic [16:0] beta_q;
	logic [16:0] gbeta_q;
	logic [3:0]  cnt_q;
	logic [31:0] m_q;
	logic [16:0] l2_q;
	logic signed [34:0] lsum_q;
	logic signed [33:0] gprod_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	pix_t        ram_wdata;
	logic        ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [$bits(pix_t)-1:0] ram_rdata;
	pix_t        rd_pix;

	logic        out_free;
	logic        pop;
	logic        out_load;
	out_item_t   out_next;
	logic        neg;

	logic [16:0] b_eff;
	logic [16:0] gb_eff;
	logic signed [33:0] p1;
	logic [28:0] p2;
	logic signed [33:0] gp;
	logic signed [13:0] th;
	logic signed [15:0] l_new;
	logic signed [15:0] g_new;
	logic [13:0] x6;
	logic [15:0] qsum;
	logic [31:0] m0;
	logic [63:0] sq;
	logic [31:0] mm;
	logic [32:0] fp;
	logic [55:0] cp;
	logic [55:0] gpr;
	logic [32:0] bp;
	logic [32:0] gbp;

	epcf_ram #(
		.WIDTH($bits(pix_t)),
		.DEPTH(NPIX)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_pix            = pix_t'(ram_rdata);
	assign out_free          = !out_valid_q || !out_stall;
	assign neg               = job_q.time_us < rd_pix.last;
	assign back_ctl.pop      = pop;
	assign back_ctl.clearing = (state_q == ST_CLR);
	assign out_valid         = out_valid_q;
	assign out_data          = out_q;

	always_comb begin
		b_eff  = cbig_q ? 17'd0 : beta_q;
		gb_eff = gbig_q ? 17'd0 : gbeta_q;
		p1     = $signed({1'b0, b_eff}) * $signed(word_q.log_v);
		p2     = 29'(17'd65536 - b_eff) * 29'(word_q.frame);
		gp     = $signed({1'b0, gb_eff}) * $signed(word_q.guide_v);
		if (job_q.kind == KIND_EVENT)
			th = job_q.polarity ? $signed({2'b00, cfg.th_on}) : 14'(cfg.th_off);
		else
			th = 14'sd0;
		l_new  = sat16(21'(rnd16(lsum_q)) + 21'(th));
		g_new  = sat16(21'(rnd16(35'(gprod_q))) + 21'(th));
		x6     = {job_q.frame_pixel, 6'b0};
		qsum   = (16'(x6) + 16'(x6 >> 8) + 16'd1) >> 8;
		m0     = 32'h4000_0000 + 32'(job_q.frame_pixel) * 32'd4210752 + 32'(qsum);
		sq     = 64'(m_q) * 64'(m_q);
		mm     = sq[61:30];
		fp     = 33'(l2_q) * 33'd45426 + 33'd524288;
		cp     = 56'(cfg.cutoff) * 56'(dt_q);
		gpr    = 56'(cfg.guide_rate) * 56'(dt_q);
		bp     = 33'(beta_q) * 33'(exp_tab(cnt_q)) + 33'd32768;
		gbp    = 33'(gbeta_q) * 33'(exp_tab(cnt_q)) + 33'd32768;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_q == ADDR_W'(NPIX - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (job_req.valid && out_free)
					state_d = ST_RD;
			end
			ST_RD: begin
				unique case (job_q.kind) inside
					KIND_EVENT, KIND_READ: state_d = neg ? ST_IDLE : ST_MUL;
					KIND_FRAME:            state_d = ST_SQ;
					default:               state_d = ST_IDLE;
				endcase
			end
			ST_MUL:  state_d = ST_EXP;
			ST_EXP: begin
				if (cnt_q == 4'd15)
					state_d = ST_BLD;
			end
			ST_BLD:  state_d = ST_FIN;
			ST_FIN:  state_d = ST_IDLE;
			ST_SQ: begin
				if (cnt_q == 4'd15)
					state_d = ST_FLOG;
			end
			ST_FLOG: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = job_q.addr;
		ram_wdata = word_q;
		ram_re    = 1'b0;
		ram_raddr = job_req.job.addr;
		pop       = 1'b0;
		out_load  = 1'b0;
		out_next  = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '{log_v: 16'sd0, guide_v: 16'sd0, last: 32'd0,
					frame: FRAME_RESET};
			end
			ST_IDLE: begin
				if (job_req.valid && out_free) begin
					pop    = 1'b1;
					ram_re = 1'b1;
				end
			end
			ST_RD: begin
				unique case (job_q.kind) inside
					KIND_EVENT, KIND_READ: begin
						if (neg) begin
							out_load = 1'b1;
							out_next = '{log_intensity: rd_pix.log_v,
								guide_value: rd_pix.guide_v, status: 1'b1};
						end
					end
					KIND_FRAME: begin
						out_load = 1'b0;
					end
					KIND_NOP: begin
						out_load = 1'b1;
						out_next = '{log_intensity: rd_pix.log_v,
							guide_value: rd_pix.guide_v, status: 1'b0};
					end
					default: begin
						out_load = 1'b1;
					end
				endcase
			end
			ST_FIN: begin
				ram_we    = 1'b1;
				ram_wdata = '{log_v: l_new, guide_v: g_new, last: job_q.time_us,
					frame: word_q.frame};
				out_load  = 1'b1;
				out_next  = '{log_intensity: l_new, guide_value: g_new, status: 1'b0};
			end
			ST_FLOG: begin
				ram_we    = 1'b1;
				ram_wdata = '{log_v: word_q.log_v, guide_v: word_q.guide_v,
					last: word_q.last, frame: fp[31:20]};
				out_load  = 1'b1;
				out_next  = '{log_intensity: word_q.log_v, guide_value: word_q.guide_v,
					status: 1'b0};
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR)
				clr_q <= clr_q + ADDR_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_next;
		case (state_q)
			ST_IDLE: begin
				if (pop)
					job_q <= job_req.job;
			end
			ST_RD: begin
				word_q <= rd_pix;
				dt_q   <= job_q.time_us - rd_pix.last;
				cnt_q  <= 4'd0;
				if (m0[31]) begin
					m_q  <= m0 >> 1;
					l2_q <= 17'h10000;
				end else begin
					m_q  <= m0;
					l2_q <= 17'd0;
				end
			end
			ST_MUL: begin
				ac_q    <= cp[35:20];
				cbig_q  <= |cp[55:36];
				ag_q    <= gpr[35:20];
				gbig_q  <= |gpr[55:36];
				beta_q  <= 17'h10000;
				gbeta_q <= 17'h10000;
				cnt_q   <= 4'd0;
			end
			ST_EXP: begin
				if (ac_q[cnt_q])
					beta_q <= bp[32:16];
				if (ag_q[cnt_q])
					gbeta_q <= gbp[32:16];
				cnt_q <= cnt_q + 4'd1;
			end
			ST_BLD: begin
				lsum_q  <= 35'(p1) + $signed({6'b0, p2});
				gprod_q <= gp;
			end
			ST_SQ: begin
				m_q   <= mm[31] ? (mm >> 1) : mm;
				l2_q  <= l2_q | (17'(mm[31]) << (4'd15 - cnt_q));
				cnt_q <= cnt_q + 4'd1;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule
